// ----- rtl/lsfc_pkg.sv -----
// Shared types and constants of the LED strobe and flasher controller.
package lsfc_pkg;

	// Button and timer events carried by one input beat.
	typedef enum logic [2:0] {
		OP_ENTER              = 3'd0,
		OP_CLICK              = 3'd1,
		OP_DOUBLE_CLICK       = 3'd2,
		OP_HOLD_TICK          = 3'd3,
		OP_HOLD_RELEASE       = 3'd4,
		OP_CLICK_HOLD_TICK    = 3'd5,
		OP_CLICK_HOLD_RELEASE = 3'd6,
		OP_MS_TICK            = 3'd7
	} opcode_t;

	// Configuration register indexes.
	localparam logic [1:0] REG_STROBE_LEVEL    = 2'd0;
	localparam logic [1:0] REG_BURST_CAP       = 2'd1;
	localparam logic [1:0] REG_MAX_FLASH_LEVEL = 2'd2;

	localparam logic [7:0] STROBE_LEVEL_RST    = 8'd150;
	localparam logic [7:0] BURST_CAP_RST       = 8'd150;
	localparam logic [6:0] MAX_FLASH_LEVEL_RST = 7'd120;

	localparam int unsigned NUM_MODES = 2;
	localparam logic [7:0] DEFAULT_DELAY       = 8'd67;
	localparam logic [7:0] DEFAULT_FLASH_LEVEL = 8'd60;

	localparam logic [7:0] DELAY_MIN      = 8'd8;
	localparam logic [7:0] DELAY_MAX      = 8'd254;
	localparam logic [7:0] DELAY_SLOW_MAX = 8'd255;
	localparam logic [7:0] BRIGHT_MIN     = 8'd2;

	// Pattern phases: tactical 0 on, 1 off; flasher 0..7 burst/base, 8 long hold.
	localparam logic [3:0] TAC_LAST   = 4'd1;
	localparam logic [3:0] FLASH_LAST = 4'd8;
	localparam logic [9:0] BURST_MS   = 10'd5;
	localparam logic [9:0] GAP_MS     = 10'd65;
	localparam logic [9:0] HOLD_MS    = 10'd720;

	typedef struct packed {
		logic [7:0] strobe_level;
		logic [7:0] burst_cap;
		logic [6:0] max_flash_level;
	} cfg_t;

	typedef struct packed {
		logic [3:0] phase;
		logic [9:0] ms_left;
	} pat_t;

	typedef struct packed {
		logic [7:0] light_level;
		logic       go_off;
		logic       save_settings;
		logic       handled;
	} result_t;

endpackage

// ----- rtl/lsfc_pattern.sv -----
// Millisecond pattern sequencer: phase load, level selection and countdown.
module lsfc_pattern import lsfc_pkg::*; (
	input  logic       flasher,
	input  logic [7:0] delay,
	input  logic [7:0] bright,
	input  cfg_t       cfg,
	input  pat_t       cur,
	output pat_t       nxt,
	output logic [7:0] level
);

	function automatic logic [9:0] phase_len(input logic f, input logic [3:0] ph,
			input logic [7:0] dly);
		logic [9:0] len;
		if (!f) begin
			len = (ph == 4'd0) ? {3'b000, dly[7:1]} : {2'b00, dly};
		end else if (ph >= FLASH_LAST) begin
			len = HOLD_MS;
		end else begin
			len = ph[0] ? GAP_MS : BURST_MS;
		end
		return len;
	endfunction

	function automatic logic [3:0] next_phase(input logic [3:0] ph, input logic [3:0] lst);
		return (ph >= lst) ? 4'd0 : ph + 4'd1;
	endfunction

	logic [3:0] last;
	logic [3:0] ph0, ph1;
	logic [9:0] left0, left1, len0;
	logic [8:0] burst;

	always_comb begin
		last = flasher ? FLASH_LAST : TAC_LAST;
		if (cur.phase > last) begin
			ph0   = 4'd0;
			left0 = 10'd0;
		end else begin
			ph0   = cur.phase;
			left0 = cur.ms_left;
		end
		len0  = phase_len(flasher, ph0, delay);
		ph1   = ph0;
		left1 = left0;
		// An empty phase is skipped. Only a short tactical on phase can be empty,
		// and the off phase after it is then never empty.
		if (left0 == 10'd0) begin
			left1 = len0;
			if (len0 == 10'd0) begin
				ph1   = next_phase(ph0, last);
				left1 = phase_len(flasher, ph1, delay);
			end
		end

		burst = {bright, 1'b0};
		if (!flasher) begin
			level = (ph1 == 4'd0) ? cfg.strobe_level : 8'd0;
		end else if (ph1 >= FLASH_LAST || ph1[0]) begin
			level = bright;
		end else if (burst > {1'b0, cfg.burst_cap}) begin
			level = cfg.burst_cap;
		end else begin
			level = burst[7:0];
		end

		if (left1 != 10'd0) begin
			nxt.ms_left = left1 - 10'd1;
			nxt.phase   = (left1 == 10'd1) ? next_phase(ph1, last) : ph1;
		end else begin
			nxt.ms_left = 10'd0;
			nxt.phase   = ph1;
		end
	end

endmodule

// ----- rtl/lsfc_ctrl.sv -----
// Controller state and event decode: mode, ramp direction, delay and brightness.
module lsfc_ctrl import lsfc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  opcode_t op,
	input  logic    even,
	input  cfg_t    cfg,
	output result_t res
);

	logic       mode_q, mode_d;
	logic       ramp_up_q, ramp_up_d;
	logic [7:0] delay_q, delay_d;
	logic [7:0] bright_q, bright_d;
	pat_t       pat_q, pat_d;

	pat_t       pat_tick;
	logic [7:0] tick_level;

	logic signed [9:0] d_sum;
	logic signed [9:0] b_sum;

	lsfc_pattern u_pattern (
		.flasher (mode_q),
		.delay   (delay_q),
		.bright  (bright_q),
		.cfg     (cfg),
		.cur     (pat_q),
		.nxt     (pat_tick),
		.level   (tick_level)
	);

	always_comb begin
		mode_d    = mode_q;
		ramp_up_d = ramp_up_q;
		delay_d   = delay_q;
		bright_d  = bright_q;
		pat_d     = pat_q;
		res       = '0;
		res.handled = 1'b1;

		// Ramp faster means a shorter delay; ramp brighter means a higher level.
		d_sum = $signed({2'b00, delay_q}) + (ramp_up_q ? -10'sd1 : 10'sd1);
		b_sum = $signed({2'b00, bright_q}) + (ramp_up_q ? 10'sd1 : -10'sd1);

		case (op)
			OP_ENTER: begin
				ramp_up_d = 1'b1;
				pat_d     = '0;
			end
			OP_CLICK: begin
				res.go_off = 1'b1;
			end
			OP_DOUBLE_CLICK: begin
				mode_d            = (NUM_MODES > 1) ? ~mode_q : 1'b0;
				res.save_settings = 1'b1;
				pat_d             = '0;
			end
			OP_HOLD_TICK: begin
				if (!mode_q) begin
					if (even) begin
						if (d_sum < $signed({2'b00, DELAY_MIN})) begin
							delay_d = DELAY_MIN;
						end else if (d_sum > $signed({2'b00, DELAY_MAX})) begin
							delay_d = DELAY_MAX;
						end else begin
							delay_d = d_sum[7:0];
						end
					end
				end else begin
					if (b_sum < $signed({2'b00, BRIGHT_MIN})) begin
						bright_d = BRIGHT_MIN;
					end else if (b_sum > $signed({3'b000, cfg.max_flash_level})) begin
						bright_d = {1'b0, cfg.max_flash_level};
					end else begin
						bright_d = b_sum[7:0];
					end
					res.light_level = bright_d;
				end
			end
			OP_HOLD_RELEASE: begin
				ramp_up_d         = ~ramp_up_q;
				res.save_settings = 1'b1;
			end
			OP_CLICK_HOLD_TICK: begin
				ramp_up_d = 1'b1;
				if (!mode_q) begin
					if (even && delay_q < DELAY_SLOW_MAX) begin
						delay_d = delay_q + 8'd1;
					end
				end else begin
					if (bright_q > BRIGHT_MIN) begin
						bright_d = bright_q - 8'd1;
					end
					res.light_level = bright_d;
				end
			end
			OP_CLICK_HOLD_RELEASE: begin
				res.save_settings = 1'b1;
			end
			OP_MS_TICK: begin
				res.handled     = 1'b0;
				res.light_level = tick_level;
				pat_d           = pat_tick;
			end
			default: begin
				res.handled = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= 1'b0;
			ramp_up_q <= 1'b1;
			delay_q   <= DEFAULT_DELAY;
			bright_q  <= DEFAULT_FLASH_LEVEL;
			pat_q     <= '0;
		end else if (step) begin
			mode_q    <= mode_d;
			ramp_up_q <= ramp_up_d;
			delay_q   <= delay_d;
			bright_q  <= bright_d;
			pat_q     <= pat_d;
		end
	end

`ifndef SYNTH
	// The delay ramp and the slow-down step never leave the delay below its floor.
	a_delay_floor: assert property (@(posedge clk) disable iff (!arst_n)
		delay_q >= DELAY_MIN)
		else $error("strobe delay below floor");

	// A mode change restarts the pattern, so tactical mode never sees a flasher phase.
	a_tac_phase: assert property (@(posedge clk) disable iff (!arst_n)
		!mode_q |-> pat_q.phase <= TAC_LAST)
		else $error("tactical phase out of range");

	a_ms_left: assert property (@(posedge clk) disable iff (!arst_n)
		pat_q.ms_left <= HOLD_MS && pat_q.phase <= FLASH_LAST)
		else $error("pattern counter out of range");
`endif

endmodule

// ----- rtl/led_strobe_flasher_controller_top.sv -----
// Top level of the LED strobe and flasher controller: input and result stages.
//
//  Channel   Signals                                         Beat accepted when
//  --------  ----------------------------------------------  ------------------------
//  input     in_valid, in_ready, opcode, hold_count           in_valid && in_ready
//  result    out_valid, out_ready, light_level, go_off,       out_valid && out_ready
//            save_settings, handled
//  config    cfg_we, cfg_index, cfg_wdata                     cfg_we
//
// One input beat can be taken every cycle while out_ready is high; each beat yields
// exactly one result beat. The event is registered in the input stage on acceptance,
// and its result is registered in the result stage when the input stage advances.
// The whole event update is one pass through the controller logic between the input
// and result registers, so throughput is one beat per cycle while out_ready is high.
// Reset (arst_n low) empties both stages and restores the configuration and
// controller state to their defaults. When out_ready is low, the result stage
// holds; the input stage keeps taking a beat until it too is full.
module led_strobe_flasher_controller_top import lsfc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  opcode,
	input  logic [15:0] hold_count,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  light_level,
	output logic        go_off,
	output logic        save_settings,
	output logic        handled,

	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_wdata
);

	// Configuration registers.
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.strobe_level    <= STROBE_LEVEL_RST;
			cfg_q.burst_cap       <= BURST_CAP_RST;
			cfg_q.max_flash_level <= MAX_FLASH_LEVEL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STROBE_LEVEL:    cfg_q.strobe_level    <= cfg_wdata;
				REG_BURST_CAP:       cfg_q.burst_cap       <= cfg_wdata;
				REG_MAX_FLASH_LEVEL: cfg_q.max_flash_level <= cfg_wdata[6:0];
				default: begin
					// Writes past the last register are dropped.
				end
			endcase
		end
	end

	// Input stage: holds the event and the parity of the hold count, which is
	// all the controller needs of it.
	logic    valid_s1;
	opcode_t op_s1;
	logic    even_s1;

	// Result stage.
	logic    valid_s2;
	result_t res_s2;
	result_t res_d;

	// The input stage moves on whenever the result stage is empty or drains.
	logic adv;

	assign adv      = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1   <= opcode_t'(opcode);
			even_s1 <= ~hold_count[0];
		end
	end

	// The controller commits its state update in the same cycle the result
	// is captured, so every event is applied exactly once.
	lsfc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.op     (op_s1),
		.even   (even_s1),
		.cfg    (cfg_q),
		.res    (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_d;
		end
	end

	assign out_valid     = valid_s2;
	assign light_level   = res_s2.light_level;
	assign go_off        = res_s2.go_off;
	assign save_settings = res_s2.save_settings;
	assign handled       = res_s2.handled;

`ifndef SYNTH
	// An event that leaves the input stage always lands in the result stage.
	a_adv_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s2)
		else $error("advanced event did not reach result stage");

	// A millisecond tick is never consumed and never requests off or a save.
	a_tick_flags: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !res_s2.handled |-> !res_s2.go_off && !res_s2.save_settings)
		else $error("unhandled tick carries a request");

	// A waiting result beat keeps its payload until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(res_s2))
		else $error("waiting result beat changed");
`endif

endmodule
